// ----- src/gbrf_pkg.sv -----
// Shared types and constants of the glyph blit and rectangle fill unit.
package gbrf_pkg;

    localparam int LANES     = 8;
    localparam int LANE_W    = 3;
    localparam int COL_W     = 14;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 12;

    localparam logic [PIX_W-1:0] WHITE    = 8'd255;
    localparam logic [PIX_W-1:0] MSB_ONLY = 8'd128;
    localparam logic [PIX_W-1:0] ALL_BITS = 8'd255;

    typedef logic signed [COL_W-1:0] t_coord;

    localparam t_coord COORD_ONE = 14'sd1;

    typedef enum logic [1:0] {
        OP_GLYPH = 2'd0,
        OP_FILL  = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH  = 3'd0,
        CFG_CANVAS_HEIGHT = 3'd1,
        CFG_GLYPH_X       = 3'd2,
        CFG_GLYPH_Y       = 3'd3,
        CFG_GLYPH_WIDTH   = 3'd4,
        CFG_GLYPH_ROWS    = 3'd5,
        CFG_GLYPH_PITCH   = 3'd6,
        CFG_MONO_MODE     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             force_wr;
        logic             and_not;
        t_coord           c0;
        t_coord           row;
        t_coord           lo;
        t_coord           hi;
        logic [PIX_W-1:0] bits;
        logic [PIX_W-1:0] data;
    } t_lane_cmd;

endpackage

// ----- src/gbrf_if.sv -----
// Handshake interfaces for the item and result channels.
interface gbrf_item_if;
    import gbrf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [PIX_W-1:0]          data_byte;
    logic                      restart;
    logic signed [COORD_W-1:0] col_a;
    logic signed [COORD_W-1:0] row_a;
    logic signed [COORD_W-1:0] col_b;
    logic signed [COORD_W-1:0] row_b;

    modport source (
        output valid, opcode, data_byte, restart, col_a, row_a, col_b, row_b,
        input  ready
    );
    modport sink (
        input  valid, opcode, data_byte, restart, col_a, row_a, col_b, row_b,
        output ready
    );
endinterface

interface gbrf_result_if;
    import gbrf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             in_range;

    modport source (output valid, pixel, in_range, input ready);
    modport sink (input valid, pixel, in_range, output ready);
endinterface

// ----- src/gbrf_lane.sv -----
// One canvas bank holding every eighth column, with its pixel decision logic.
module gbrf_lane #(
    parameter int LANE  = 0,
    parameter int WPR   = 128,
    parameter int DEPTH = 32768
) (
    input  logic                      i_clk,
    input  gbrf_pkg::t_lane_cmd       i_cmd,
    output logic [gbrf_pkg::PIX_W-1:0] o_rd_data
);
    import gbrf_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [PIX_W-1:0]  r_mem [DEPTH];
    logic [PIX_W-1:0]  r_rd;

    logic [LANE_W-1:0] k;
    t_coord            col;
    logic [COL_W-1:0]  col_u;
    logic              hit;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;

    always_comb begin
        k     = LANE_W'(LANE) - i_cmd.c0[LANE_W-1:0];
        col   = i_cmd.c0 + signed'(COL_W'(k));
        col_u = unsigned'(col);
        hit   = i_cmd.bits[LANE_W'(PIX_W - 1) - k] && (col >= i_cmd.lo) && (col <= i_cmd.hi);
        we    = i_cmd.wr_en && (i_cmd.force_wr || hit);
        addr  = ADDR_W'(unsigned'(i_cmd.row)) * ADDR_W'(WPR)
              + ADDR_W'(col_u[COL_W-1:LANE_W]);
        wdata = i_cmd.and_not ? (r_rd & ~i_cmd.data) : i_cmd.data;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ----- src/gbrf_merge.sv -----
// Picks the read lane and holds the result word until it is taken.
module gbrf_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [gbrf_pkg::LANES-1:0][gbrf_pkg::PIX_W-1:0] i_rd_data,
    input  logic [gbrf_pkg::LANE_W-1:0]            i_sel,
    input  logic                                   i_hit,
    input  logic                                   i_load,
    output logic                                   o_free,
    gbrf_result_if.source                          o_result
);
    import gbrf_pkg::*;

    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic             r_in_range;
    logic             n_valid;
    logic             load;

    always_comb begin
        o_free  = !r_valid || o_result.ready;
        load    = i_load && o_free;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (load) begin
            r_pixel    <= i_hit ? i_rd_data[i_sel] : '0;
            r_in_range <= i_hit;
        end
    end

    assign o_result.valid    = r_valid;
    assign o_result.pixel    = r_pixel;
    assign o_result.in_range = r_in_range;

endmodule

// ----- src/glyph_blit_and_rect_fill_unit.sv -----
// Top level of the glyph blit and rectangle fill unit.
// The canvas is split over eight banks by column, so eight neighbouring pixels are written in
// the same cycle. After reset a clearing pass writes white over the canvas, one row of eight pixels
// per cycle, and no word is accepted until it ends. A stream of mono glyph bytes runs at one
// word per cycle. A gray glyph byte that lands inside the glyph takes a read and then a write of
// the same bank. A fill writes each aligned eight-column group that its clipped rectangle
// touches, one canvas row after another. A read passes through S_RDISS and then S_RDWAIT, where
// it waits as long as the previous result has not been taken.
module glyph_blit_and_rect_fill_unit #(
    parameter int CANVAS_COLS  = 1024,
    parameter int CANVAS_LINES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbrf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gbrf_pkg::CFG_W-1:0]        i_cfg_data,
    gbrf_item_if.sink                         i_item,
    gbrf_result_if.source                     o_result
);
    import gbrf_pkg::*;

    localparam int WPR   = (CANVAS_COLS + LANES - 1) / LANES;
    localparam int ROW_W = $clog2(CANVAS_LINES);
    localparam int GRP_W = (WPR > 1) ? $clog2(WPR) : 1;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_FILL   = 6'b000100,
        S_GRAY   = 6'b001000,
        S_RDISS  = 6'b010000,
        S_RDWAIT = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    t_lane_cmd                 r_cmd, n_cmd;
    logic [7:0]                r_src_row, n_src_row;
    logic [7:0]                r_src_byte, n_src_byte;
    logic [ROW_W-1:0]          r_row, n_row;
    logic [ROW_W-1:0]          r_row_last, n_row_last;
    logic [GRP_W-1:0]          r_grp, n_grp;
    logic [GRP_W-1:0]          r_grp_first, n_grp_first;
    logic [GRP_W-1:0]          r_grp_last, n_grp_last;
    t_coord                    r_lo, n_lo;
    t_coord                    r_hi, n_hi;
    logic [PIX_W-1:0]          r_gray, n_gray;
    logic [LANE_W-1:0]         r_sel, n_sel;
    logic                      r_hit, n_hit;

    logic [10:0]               r_canvas_width;
    logic [8:0]                r_canvas_height;
    logic signed [COORD_W-1:0] r_glyph_x;
    logic signed [COORD_W-1:0] r_glyph_y;
    logic [7:0]                r_glyph_width;
    logic [7:0]                r_glyph_rows;
    logic [7:0]                r_glyph_pitch;
    logic                      r_mono_mode;

    logic [LANES-1:0][PIX_W-1:0] lane_rd;
    logic                      merge_free;

    t_coord                    aw, ah, aw_m1, ah_m1;
    t_coord                    gx, gy, g_row, g_col_mono, g_col_gray, g_hi, mono_hi;
    t_coord                    ca, ra, cb, rb, fl, ft, fr, fb;
    logic [7:0]                pos_row, pos_byte, row_len;
    logic [8:0]                byte_inc;
    logic                      row_ok;
    logic                      rd_inside;

    always_comb begin
        aw = (COL_W'(r_canvas_width) < COL_W'(CANVAS_COLS))
           ? t_coord'(COL_W'(r_canvas_width)) : t_coord'(COL_W'(CANVAS_COLS));
        ah = (COL_W'(r_canvas_height) < COL_W'(CANVAS_LINES))
           ? t_coord'(COL_W'(r_canvas_height)) : t_coord'(COL_W'(CANVAS_LINES));
        aw_m1 = aw - COORD_ONE;
        ah_m1 = ah - COORD_ONE;

        gx = COL_W'(r_glyph_x);
        gy = COL_W'(r_glyph_y);
        pos_row  = i_item.restart ? 8'd0 : r_src_row;
        pos_byte = i_item.restart ? 8'd0 : r_src_byte;
        row_len  = r_mono_mode ? r_glyph_pitch : r_glyph_width;
        if (row_len == 8'd0) begin
            row_len = 8'd1;
        end
        byte_inc   = {1'b0, pos_byte} + 9'd1;
        g_row      = gy + signed'(COL_W'(pos_row));
        row_ok     = (pos_row < r_glyph_rows) && !g_row[COL_W-1] && (g_row < ah);
        g_col_mono = gx + signed'(COL_W'({pos_byte, 3'b000}));
        g_col_gray = gx + signed'(COL_W'(pos_byte));
        g_hi       = gx + signed'(COL_W'(r_glyph_width)) - COORD_ONE;
        mono_hi    = (g_hi < aw_m1) ? g_hi : aw_m1;

        ca = COL_W'(i_item.col_a);
        ra = COL_W'(i_item.row_a);
        cb = COL_W'(i_item.col_b);
        rb = COL_W'(i_item.row_b);
        fl = ca[COL_W-1] ? '0 : ca;
        ft = ra[COL_W-1] ? '0 : ra;
        fr = (cb > aw_m1) ? aw_m1 : cb;
        fb = (rb > ah_m1) ? ah_m1 : rb;
        rd_inside = !ca[COL_W-1] && !ra[COL_W-1] && (ca < aw) && (ra < ah);
    end

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cmd       = '0;
        n_src_row   = r_src_row;
        n_src_byte  = r_src_byte;
        n_row       = r_row;
        n_row_last  = r_row_last;
        n_grp       = r_grp;
        n_grp_first = r_grp_first;
        n_grp_last  = r_grp_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_gray      = r_gray;
        n_sel       = r_sel;
        n_hit       = r_hit;

        unique case (r_state)
            S_CLEAR: begin
                n_cmd.wr_en    = 1'b1;
                n_cmd.force_wr = 1'b1;
                n_cmd.c0       = signed'(COL_W'({r_grp, 3'b000}));
                n_cmd.row      = signed'(COL_W'(r_row));
                n_cmd.bits     = ALL_BITS;
                n_cmd.data     = WHITE;
                if (r_grp == GRP_W'(WPR - 1)) begin
                    n_grp = '0;
                    if (r_row == ROW_W'(CANVAS_LINES - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_grp = r_grp + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    unique case (i_item.opcode)
                        OP_GLYPH: begin
                            n_src_row = pos_row;
                            if (byte_inc >= {1'b0, row_len}) begin
                                n_src_byte = '0;
                                if (pos_row != 8'd255) begin
                                    n_src_row = pos_row + 8'd1;
                                end
                            end else begin
                                n_src_byte = byte_inc[7:0];
                            end
                            n_cmd.row = g_row;
                            n_cmd.lo  = '0;
                            if (r_mono_mode) begin
                                n_cmd.wr_en = row_ok;
                                n_cmd.c0    = g_col_mono;
                                n_cmd.hi    = mono_hi;
                                n_cmd.bits  = i_item.data_byte;
                                n_cmd.data  = '0;
                            end else if (row_ok && (pos_byte < r_glyph_width)) begin
                                n_cmd.rd_en = 1'b1;
                                n_cmd.c0    = g_col_gray;
                                n_cmd.hi    = aw_m1;
                                n_cmd.bits  = MSB_ONLY;
                                n_cmd.data  = i_item.data_byte;
                                n_state     = S_GRAY;
                            end
                        end
                        OP_FILL: begin
                            if ((fl <= fr) && (ft <= fb)) begin
                                n_state     = S_FILL;
                                n_lo        = fl;
                                n_hi        = fr;
                                n_grp       = fl[GRP_W+LANE_W-1:LANE_W];
                                n_grp_first = fl[GRP_W+LANE_W-1:LANE_W];
                                n_grp_last  = fr[GRP_W+LANE_W-1:LANE_W];
                                n_row       = ft[ROW_W-1:0];
                                n_row_last  = fb[ROW_W-1:0];
                                n_gray      = i_item.data_byte;
                            end
                        end
                        OP_READ: begin
                            n_cmd.rd_en = rd_inside;
                            n_cmd.c0    = ca;
                            n_cmd.row   = ra;
                            n_sel       = ca[LANE_W-1:0];
                            n_hit       = rd_inside;
                            n_state     = S_RDISS;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_GRAY: begin
                n_cmd         = r_cmd;
                n_cmd.rd_en   = 1'b0;
                n_cmd.wr_en   = 1'b1;
                n_cmd.and_not = 1'b1;
                n_state       = S_IDLE;
            end
            S_FILL: begin
                n_cmd.wr_en = 1'b1;
                n_cmd.c0    = signed'(COL_W'({r_grp, 3'b000}));
                n_cmd.row   = signed'(COL_W'(r_row));
                n_cmd.lo    = r_lo;
                n_cmd.hi    = r_hi;
                n_cmd.bits  = ALL_BITS;
                n_cmd.data  = r_gray;
                if (r_grp == r_grp_last) begin
                    n_grp = r_grp_first;
                    if (r_row == r_row_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_grp = r_grp + 1'b1;
                end
            end
            S_RDISS: begin
                n_state = S_RDWAIT;
            end
            S_RDWAIT: begin
                if (merge_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cmd      <= '0;
            r_src_row  <= '0;
            r_src_byte <= '0;
            r_row      <= '0;
            r_grp      <= '0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= n_cmd;
            r_src_row  <= n_src_row;
            r_src_byte <= n_src_byte;
            r_row      <= n_row;
            r_grp      <= n_grp;
        end
        r_row_last  <= n_row_last;
        r_grp_first <= n_grp_first;
        r_grp_last  <= n_grp_last;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_gray      <= n_gray;
        r_sel       <= n_sel;
        r_hit       <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= 11'd1024;
            r_canvas_height <= 9'd256;
            r_glyph_x       <= '0;
            r_glyph_y       <= '0;
            r_glyph_width   <= '0;
            r_glyph_rows    <= '0;
            r_glyph_pitch   <= 8'd1;
            r_mono_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data[10:0];
                CFG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data[8:0];
                CFG_GLYPH_X:       r_glyph_x       <= signed'(i_cfg_data);
                CFG_GLYPH_Y:       r_glyph_y       <= signed'(i_cfg_data);
                CFG_GLYPH_WIDTH:   r_glyph_width   <= i_cfg_data[7:0];
                CFG_GLYPH_ROWS:    r_glyph_rows    <= i_cfg_data[7:0];
                CFG_GLYPH_PITCH:   r_glyph_pitch   <= i_cfg_data[7:0];
                CFG_MONO_MODE:     r_mono_mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        gbrf_lane #(
            .LANE  (j),
            .WPR   (WPR),
            .DEPTH (CANVAS_LINES * WPR)
        ) u_lane (
            .i_clk     (i_clk),
            .i_cmd     (r_cmd),
            .o_rd_data (lane_rd[j])
        );
    end

    gbrf_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_data (lane_rd),
        .i_sel     (r_sel),
        .i_hit     (r_hit),
        .i_load    (r_state == S_RDWAIT),
        .o_free    (merge_free),
        .o_result  (o_result)
    );

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("Sequencer state is not one-hot.");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == S_RDWAIT))
        else $error("Result word appeared without a read.");

    a_gray_reads_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRAY) |-> (r_cmd.rd_en && !r_cmd.wr_en))
        else $error("Gray glyph write issued without its read.");

    a_and_not_after_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.and_not |-> $past(r_state == S_GRAY))
        else $error("Masked write outside a gray glyph byte.");

    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ((r_grp <= r_grp_last) && (r_row <= r_row_last)))
        else $error("Fill walk ran past its rectangle.");
`endif

endmodule

// ----- tb/glyph_blit_and_rect_fill_unit_test.sv -----
// Self-checking testbench for the glyph blit and rectangle fill unit, driven by directed and random words.
module glyph_blit_and_rect_fill_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbrf_pkg::*;

    localparam int CANVAS_COLS  = 1024;
    localparam int CANVAS_LINES = 256;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]                op;
        logic [PIX_W-1:0]          data;
        logic                      restart;
        logic signed [COORD_W-1:0] col_a;
        logic signed [COORD_W-1:0] row_a;
        logic signed [COORD_W-1:0] col_b;
        logic signed [COORD_W-1:0] row_b;
    } draw_cmd_t;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             in_range;
    } pixel_read_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    gbrf_item_if   item_ch ();
    gbrf_result_if result_ch ();

    glyph_blit_and_rect_fill_unit #(
        .CANVAS_COLS (CANVAS_COLS),
        .CANVAS_LINES(CANVAS_LINES)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_item    (item_ch),
        .o_result  (result_ch)
    );

    bit [PIX_W-1:0]         canvas_img [CANVAS_COLS*CANVAS_LINES];
    int unsigned            glyph_row_pos;
    int unsigned            glyph_byte_pos;
    logic [10:0]            reg_canvas_w;
    logic [8:0]             reg_canvas_h;
    logic signed [11:0]     reg_glyph_x;
    logic signed [11:0]     reg_glyph_y;
    logic [7:0]             reg_glyph_w;
    logic [7:0]             reg_glyph_rows;
    logic [7:0]             reg_glyph_pitch;
    logic                   reg_mono;

    pixel_read_t pending_reads [$];
    int          mismatches = 0;
    int          item_calm = 0;
    int          result_calm = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Mostly random waits, with occasional stretches of back-to-back traffic.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic signed [COORD_W-1:0] to_coord(input int v);
        if (v < -2048) begin
            return -12'sd2048;
        end
        if (v > 2047) begin
            return 12'sd2047;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic int any_coord();
        return $urandom_range(0, 4095) - 2048;
    endfunction

    function automatic draw_cmd_t glyph_byte_cmd(input logic [7:0] d, input logic rs);
        draw_cmd_t cmd;
        cmd.op      = OP_GLYPH;
        cmd.data    = d;
        cmd.restart = rs;
        cmd.col_a   = to_coord(any_coord());
        cmd.row_a   = to_coord(any_coord());
        cmd.col_b   = to_coord(any_coord());
        cmd.row_b   = to_coord(any_coord());
        return cmd;
    endfunction

    function automatic draw_cmd_t fill_cmd(input int l, input int t, input int r, input int b,
                                           input logic [7:0] g);
        draw_cmd_t cmd;
        cmd.op      = OP_FILL;
        cmd.data    = g;
        cmd.restart = $urandom_range(0, 1);
        cmd.col_a   = to_coord(l);
        cmd.row_a   = to_coord(t);
        cmd.col_b   = to_coord(r);
        cmd.row_b   = to_coord(b);
        return cmd;
    endfunction

    function automatic draw_cmd_t read_cmd(input int c, input int r);
        draw_cmd_t cmd;
        cmd.op      = OP_READ;
        cmd.data    = $urandom_range(0, 255);
        cmd.restart = $urandom_range(0, 1);
        cmd.col_a   = to_coord(c);
        cmd.row_a   = to_coord(r);
        cmd.col_b   = to_coord(any_coord());
        cmd.row_b   = to_coord(any_coord());
        return cmd;
    endfunction

    function automatic int active_cols();
        return (reg_canvas_w < CANVAS_COLS) ? int'(reg_canvas_w) : CANVAS_COLS;
    endfunction

    function automatic int active_lines();
        return (reg_canvas_h < CANVAS_LINES) ? int'(reg_canvas_h) : CANVAS_LINES;
    endfunction

    function automatic bit on_canvas(input int c, input int r);
        return c >= 0 && r >= 0 && c < active_cols() && r < active_lines();
    endfunction

    function automatic void draw_glyph_byte(input logic [7:0] d, input logic rs);
        int unsigned row_len;
        int          r;
        int          c;
        int          p;
        if (rs) begin
            glyph_row_pos  = 0;
            glyph_byte_pos = 0;
        end
        row_len = reg_mono ? reg_glyph_pitch : reg_glyph_w;
        if (glyph_row_pos < reg_glyph_rows) begin
            r = int'(reg_glyph_y) + int'(glyph_row_pos);
            if (reg_mono) begin
                for (int k = 0; k < 8; k++) begin
                    p = int'(glyph_byte_pos) * 8 + k;
                    c = int'(reg_glyph_x) + p;
                    if (p < int'(reg_glyph_w) && d[7-k] && on_canvas(c, r)) begin
                        canvas_img[r*CANVAS_COLS+c] = 8'h00;
                    end
                end
            end else if (glyph_byte_pos < reg_glyph_w) begin
                c = int'(reg_glyph_x) + int'(glyph_byte_pos);
                if (on_canvas(c, r)) begin
                    canvas_img[r*CANVAS_COLS+c] &= ~d;
                end
            end
        end
        if (row_len == 0) begin
            row_len = 1;
        end
        glyph_byte_pos++;
        if (glyph_byte_pos >= row_len) begin
            glyph_byte_pos = 0;
            if (glyph_row_pos < 255) begin
                glyph_row_pos++;
            end
        end
    endfunction

    function automatic void fill_rect(input int l, input int t, input int r, input int b,
                                      input logic [7:0] g);
        int w;
        int h;
        w = active_cols();
        h = active_lines();
        if (l < 0) l = 0;
        if (t < 0) t = 0;
        if (r > w - 1) r = w - 1;
        if (b > h - 1) b = h - 1;
        for (int j = t; j <= b; j++) begin
            for (int i = l; i <= r; i++) begin
                canvas_img[j*CANVAS_COLS+i] = g;
            end
        end
    endfunction

    function automatic void apply_cmd(input draw_cmd_t cmd);
        pixel_read_t rd;
        case (cmd.op)
            OP_GLYPH: draw_glyph_byte(cmd.data, cmd.restart);
            OP_FILL: fill_rect(int'(cmd.col_a), int'(cmd.row_a), int'(cmd.col_b),
                               int'(cmd.row_b), cmd.data);
            OP_READ: begin
                if (on_canvas(int'(cmd.col_a), int'(cmd.row_a))) begin
                    rd.pixel    = canvas_img[int'(cmd.row_a)*CANVAS_COLS+int'(cmd.col_a)];
                    rd.in_range = 1'b1;
                end else begin
                    rd.pixel    = '0;
                    rd.in_range = 1'b0;
                end
                pending_reads.push_back(rd);
            end
            default: ;
        endcase
    endfunction

    // Offers one word to the block and updates the canvas image once it has been taken.
    task automatic push_cmd(input draw_cmd_t cmd);
        int gap;
        gap = draw_wait(item_calm);
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= cmd.op;
        item_ch.data_byte <= cmd.data;
        item_ch.restart   <= cmd.restart;
        item_ch.col_a     <= cmd.col_a;
        item_ch.row_a     <= cmd.row_a;
        item_ch.col_b     <= cmd.col_b;
        item_ch.row_b     <= cmd.row_b;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        apply_cmd(cmd);
    endtask

    // A read queues behind any fill still in progress, so its result marks the block idle.
    task automatic settle();
        push_cmd(read_cmd($urandom_range(0, 1027) - 2, $urandom_range(0, 259) - 2));
        item_ch.valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        logic [11:0] v;
        v = value[11:0];
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            CFG_CANVAS_WIDTH:  reg_canvas_w    = v[10:0];
            CFG_CANVAS_HEIGHT: reg_canvas_h    = v[8:0];
            CFG_GLYPH_X:       reg_glyph_x     = v;
            CFG_GLYPH_Y:       reg_glyph_y     = v;
            CFG_GLYPH_WIDTH:   reg_glyph_w     = v[7:0];
            CFG_GLYPH_ROWS:    reg_glyph_rows  = v[7:0];
            CFG_GLYPH_PITCH:   reg_glyph_pitch = v[7:0];
            CFG_MONO_MODE:     reg_mono        = v[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int cw, input int ch, input int gx, input int gy,
                             input int gw, input int rows, input int pitch, input int mono);
        settle();
        write_reg(CFG_CANVAS_WIDTH, cw);
        write_reg(CFG_CANVAS_HEIGHT, ch);
        write_reg(CFG_GLYPH_X, gx);
        write_reg(CFG_GLYPH_Y, gy);
        write_reg(CFG_GLYPH_WIDTH, gw);
        write_reg(CFG_GLYPH_ROWS, rows);
        write_reg(CFG_GLYPH_PITCH, pitch);
        write_reg(CFG_MONO_MODE, mono);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_after_reset();
        settle();
        push_cmd(read_cmd(0, 0));
        push_cmd(read_cmd(1023, 255));
        push_cmd(read_cmd(1024, 255));
        push_cmd(read_cmd(-2048, 2047));
    endtask

    task automatic test_fill_clipping();
        configure(2047, 511, 0, 0, 0, 0, 1, 0);
        push_cmd(fill_cmd(-2048, -2048, 2047, 2047, 8'h5A));
        push_cmd(fill_cmd(2047, 2047, -2048, -2048, 8'h00));
        push_cmd(fill_cmd(-5, -5, 3, 2, 8'hA5));
        push_cmd(fill_cmd(1030, 10, 1040, 12, 8'h00));
        push_cmd(read_cmd(3, 2));
        push_cmd(read_cmd(4, 2));
        push_cmd(read_cmd(1023, 255));
        push_cmd(read_cmd(1024, 0));
        push_cmd(read_cmd(0, 256));
    endtask

    task automatic test_mono_glyph();
        configure(1024, 256, 1018, 254, 12, 2, 2, 1);
        push_cmd(glyph_byte_cmd(8'hFF, 1'b1));
        push_cmd(glyph_byte_cmd(8'hFF, 1'b0));
        push_cmd(glyph_byte_cmd(8'hA5, 1'b0));
        push_cmd(glyph_byte_cmd(8'h3C, 1'b0));
        push_cmd(read_cmd(1023, 254));
        push_cmd(read_cmd(1018, 255));
        push_cmd(read_cmd(1019, 255));
        push_cmd(read_cmd(1020, 255));
    endtask

    task automatic test_gray_glyph();
        configure(40, 20, -1, 18, 3, 3, 0, 0);
        push_cmd(glyph_byte_cmd(8'hF0, 1'b1));
        push_cmd(glyph_byte_cmd(8'h0F, 1'b0));
        push_cmd(glyph_byte_cmd(8'hFF, 1'b0));
        push_cmd(glyph_byte_cmd(8'h55, 1'b0));
        push_cmd(glyph_byte_cmd(8'hAA, 1'b0));
        push_cmd(glyph_byte_cmd(8'h01, 1'b0));
        push_cmd(glyph_byte_cmd(8'h80, 1'b0));
        push_cmd(read_cmd(0, 18));
        push_cmd(read_cmd(1, 18));
        push_cmd(read_cmd(0, 19));
        push_cmd(read_cmd(1, 19));
    endtask

    task automatic test_zero_row_length();
        configure(1024, 256, 100, 100, 0, 4, 5, 0);
        push_cmd(glyph_byte_cmd(8'hFF, 1'b1));
        push_cmd(glyph_byte_cmd(8'hFF, 1'b0));
        push_cmd(read_cmd(100, 100));
        configure(1024, 256, 100, 100, 8, 2, 0, 1);
        push_cmd(glyph_byte_cmd(8'hF0, 1'b1));
        push_cmd(glyph_byte_cmd(8'h0F, 1'b0));
        push_cmd(glyph_byte_cmd(8'hFF, 1'b0));
        push_cmd(read_cmd(100, 100));
        push_cmd(read_cmd(104, 101));
        push_cmd(read_cmd(100, 102));
    endtask

    task automatic test_empty_canvas();
        configure(0, 256, 0, 0, 8, 1, 1, 1);
        push_cmd(fill_cmd(0, 0, 10, 10, 8'h00));
        push_cmd(glyph_byte_cmd(8'hFF, 1'b1));
        push_cmd(read_cmd(0, 0));
        configure(1024, 0, 0, 0, 8, 1, 1, 1);
        push_cmd(fill_cmd(0, 0, 10, 10, 8'h00));
        push_cmd(read_cmd(5, 5));
    endtask

    task automatic test_spare_opcode();
        draw_cmd_t cmd;
        cmd    = glyph_byte_cmd(8'h00, 1'b1);
        cmd.op = OP_SPARE;
        push_cmd(cmd);
        push_cmd(read_cmd(0, 0));
    endtask

    // Bytes sent past the last of 255 glyph rows must not wrap back onto its first row.
    task automatic test_row_overflow();
        configure(64, 256, 5, 0, 1, 255, 7, 0);
        push_cmd(fill_cmd(5, 0, 5, 0, 8'hFF));
        push_cmd(glyph_byte_cmd(8'h00, 1'b1));
        for (int i = 1; i < 262; i++) begin
            push_cmd(glyph_byte_cmd((i < 256) ? $urandom_range(0, 255) : 8'hFF, 1'b0));
        end
        push_cmd(read_cmd(5, 0));
        push_cmd(read_cmd(5, 254));
        push_cmd(read_cmd(5, 255));
    endtask

    task automatic test_random_traffic(input int target);
        int        sent;
        int        in_phase;
        int        phase_len;
        int        pick;
        int        cw, ch, aw, ah, gx, gy, gw, rows, pitch, mono;
        int        row_len, span, depth, nbytes, l, t;
        draw_cmd_t cmd;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 19);
            cw = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(1025, 2047) :
                 (pick < 6) ? 1024 : $urandom_range(1, 96);
            pick = $urandom_range(0, 19);
            ch = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(257, 511) :
                 (pick < 6) ? 256 : $urandom_range(1, 64);
            aw = (cw < CANVAS_COLS) ? cw : CANVAS_COLS;
            ah = (ch < CANVAS_LINES) ? ch : CANVAS_LINES;
            gx = ($urandom_range(0, 9) == 0) ? any_coord() : $urandom_range(0, aw + 8) - 6;
            gy = ($urandom_range(0, 9) == 0) ? any_coord() : $urandom_range(0, ah + 8) - 6;
            mono = $urandom_range(0, 1);
            pick = $urandom_range(0, 9);
            gw = (pick == 0) ? 0 : (pick == 1) ? 255 :
                 $urandom_range(1, (mono != 0) ? 24 : 10);
            pick = $urandom_range(0, 9);
            if (mono == 0 || pick == 1) begin
                pitch = $urandom_range(0, 255);
            end else begin
                pitch = (pick == 0) ? 0 : (gw + 7) / 8 + $urandom_range(0, 1);
            end
            rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
            configure(cw, ch, gx, gy, gw, rows, pitch, mono);
            row_len = (mono != 0) ? pitch : gw;
            if (row_len == 0) row_len = 1;
            span  = ((gw < 40) ? gw : 40) + 4;
            depth = ((rows < 12) ? rows : 12) + 4;
            phase_len = $urandom_range(30, 70);
            in_phase = 0;
            while (in_phase < phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    nbytes = rows * row_len;
                    if (nbytes > 96) nbytes = 96;
                    if (nbytes == 0) nbytes = 1;
                    if ($urandom_range(0, 5) == 0) nbytes = $urandom_range(1, nbytes);
                    for (int i = 0; i < nbytes; i++) begin
                        push_cmd(glyph_byte_cmd($urandom_range(0, 255), i == 0));
                    end
                    in_phase += nbytes;
                end else if (pick < 62) begin
                    if ($urandom_range(0, 39) == 0) begin
                        push_cmd(fill_cmd(any_coord(), any_coord(), any_coord(), any_coord(),
                                          $urandom_range(0, 255)));
                    end else begin
                        l = gx + $urandom_range(0, span) - 4;
                        t = gy + $urandom_range(0, depth) - 4;
                        push_cmd(fill_cmd(l, t, l + $urandom_range(0, 12) - 2,
                                          t + $urandom_range(0, 8) - 2, $urandom_range(0, 255)));
                    end
                    in_phase++;
                end else if (pick < 90) begin
                    pick = $urandom_range(0, 7);
                    if (pick == 0) begin
                        push_cmd(read_cmd(any_coord(), any_coord()));
                    end else if (pick == 1) begin
                        push_cmd(read_cmd(aw - 2 + $urandom_range(0, 2),
                                          ah - 2 + $urandom_range(0, 2)));
                    end else begin
                        push_cmd(read_cmd(gx + $urandom_range(0, span) - 2,
                                          gy + $urandom_range(0, depth) - 2));
                    end
                    in_phase++;
                end else if (pick < 96) begin
                    push_cmd(glyph_byte_cmd($urandom_range(0, 255), $urandom_range(0, 1)));
                    in_phase++;
                end else begin
                    cmd    = glyph_byte_cmd($urandom_range(0, 255), $urandom_range(0, 1));
                    cmd.op = OP_SPARE;
                    push_cmd(cmd);
                end
            end
            sent += in_phase;
        end
    endtask

    initial begin : result_sink
        int          stall;
        pixel_read_t want;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_wait(result_calm);
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
            if (pending_reads.size() == 0) begin
                report_mismatch("pixel of a result with no read pending", result_ch.pixel, -1);
            end else begin
                want = pending_reads.pop_front();
                if (result_ch.pixel !== want.pixel) begin
                    report_mismatch("pixel", result_ch.pixel, want.pixel);
                end
                if (result_ch.in_range !== want.in_range) begin
                    report_mismatch("in_range", result_ch.in_range, want.in_range);
                end
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_CANVAS_WIDTH;
        i_cfg_data        <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.opcode    <= OP_GLYPH;
        item_ch.data_byte <= '0;
        item_ch.restart   <= 1'b0;
        item_ch.col_a     <= '0;
        item_ch.row_a     <= '0;
        item_ch.col_b     <= '0;
        item_ch.row_b     <= '0;
        for (int i = 0; i < CANVAS_COLS * CANVAS_LINES; i++) begin
            canvas_img[i] = WHITE;
        end
        glyph_row_pos   = 0;
        glyph_byte_pos  = 0;
        reg_canvas_w    = 11'd1024;
        reg_canvas_h    = 9'd256;
        reg_glyph_x     = '0;
        reg_glyph_y     = '0;
        reg_glyph_w     = '0;
        reg_glyph_rows  = '0;
        reg_glyph_pitch = 8'd1;
        reg_mono        = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_fill_clipping();
        test_mono_glyph();
        test_gray_glyph();
        test_zero_row_length();
        test_empty_canvas();
        test_spare_opcode();
        test_row_overflow();
        test_random_traffic(220);
        settle();
        repeat (32) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
